// ===== sv/tss_pkg.sv =====
// Shared types, status codes and helpers of the tridiagonal solver.
package tss_pkg;

  localparam int Q_W       = 32;
  localparam int SOL_IDX_W = 6;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [1:0]            status_t;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_ZERO_PIVOT = 2'd1;
  localparam status_t ST_SAT        = 2'd2;
  localparam status_t ST_OVERRUN    = 2'd3;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  // Precedence of the kept status: overrun, then zero pivot, then saturation.
  function automatic logic [1:0] status_rank(input status_t code);
    logic [1:0] rank;
    unique case (code)
      ST_OVERRUN:    rank = 2'd3;
      ST_ZERO_PIVOT: rank = 2'd2;
      ST_SAT:        rank = 2'd1;
      ST_OK:         rank = 2'd0;
    endcase
    return rank;
  endfunction

  // Magnitude of a signed value; the most negative value maps to 2^31.
  function automatic logic [Q_W-1:0] q_abs(input q_t v);
    return v[Q_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== sv/tridiagonal_system_solver.sv =====
// Thomas tridiagonal solver with a bit-serial divider and multiplier.
// Rows: the first row is stored as it is taken; every later row takes one bit-serial
// division (32 + FRAC_BITS steps) and two 32-step multiplications.
// Back substitution: a division for the last row, a multiply and a divide for each other.
// Emission: each solution entry is read, loaded and held until the output is not stalled.
// Synchronous active-low reset clears the sequencer, row count and status; no clearing pass.
module tridiagonal_system_solver #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tss_pkg::q_t                         in_sub_coeff,
  input  tss_pkg::q_t                         in_diag_coeff,
  input  tss_pkg::q_t                         in_super_coeff,
  input  tss_pkg::q_t                         in_rhs_value,
  input  logic                                in_row_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tss_pkg::SOL_IDX_W-1:0]       out_sol_index,
  output tss_pkg::q_t                         out_sol_value,
  output tss_pkg::status_t                    out_status,
  output logic                                out_run_last
);
  import tss_pkg::*;

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_ROWS + 1);
  localparam int DW  = Q_W + FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);
  localparam int MCW = $clog2(Q_W + 1);
  localparam logic [CW-1:0]  MAX_CNT = CW'(MAX_ROWS);
  localparam logic [AW-1:0]  TOP_IDX = AW'(MAX_ROWS - 1);
  localparam logic [DCW-1:0] DIV_END = DCW'(DW);
  localparam logic [MCW-1:0] MUL_END = MCW'(Q_W);
  localparam logic signed [65:0] SAT_HI = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SAT_LO = -66'sh0_8000_0000;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIV  = 11'b000_0000_0010,
    S_MUL1 = 11'b000_0000_0100,
    S_MUL2 = 11'b000_0000_1000,
    S_BDIV = 11'b000_0001_0000,
    S_BRD  = 11'b000_0010_0000,
    S_BLD  = 11'b000_0100_0000,
    S_BMUL = 11'b000_1000_0000,
    S_ERD  = 11'b001_0000_0000,
    S_ELD  = 11'b010_0000_0000,
    S_EWT  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] row_cnt_r, row_cnt_nxt;
  status_t status_r, status_nxt;
  logic out_valid_r, out_valid_nxt;

  q_t dia_r, dia_nxt, sup_r, sup_nxt, rhs_r, rhs_nxt;
  logic last_r, last_nxt;
  q_t prev_d_r, prev_d_nxt, prev_u_r, prev_u_nxt, prev_r_r, prev_r_nxt;
  q_t p_r, p_nxt, dnew_r, dnew_nxt, x_r, x_nxt;
  logic [AW-1:0] bk_r, bk_nxt, top_r, top_nxt, eidx_r, eidx_nxt;

  logic [SOL_IDX_W-1:0] o_idx_r, o_idx_nxt;
  q_t o_val_r, o_val_nxt;
  status_t o_st_r, o_st_nxt;
  logic o_last_r, o_last_nxt;

  // Row stores and the solution store.
  q_t dmem [MAX_ROWS];
  q_t umem [MAX_ROWS];
  q_t rmem [MAX_ROWS];
  q_t xmem [MAX_ROWS];
  logic mem_we, x_we;
  logic [AW-1:0] mem_wa;
  q_t wd_d, wd_u, wd_r, x_wd;
  q_t rd_d_r, rd_u_r, rd_r_r, xrd_r;

  // Bit-serial divider.
  logic div_start;
  q_t div_num, div_den;
  logic [DW-1:0] dvd_r, quo_r;
  logic [Q_W-1:0] rem_r, dvs_r;
  logic neg_r, dzero_r;
  logic [DCW-1:0] dcnt_r;
  logic [Q_W:0] trial;
  logic div_done, div_sat;
  q_t div_res;

  // Bit-serial multiplier.
  logic mul_start;
  q_t mul_a, mul_b, mul_min;
  q_t mcand_r;
  logic [Q_W-1:0] mplr_r, lo_r;
  logic signed [Q_W+1:0] hi_r, addend, psum;
  logic [MCW-1:0] mcnt_r;
  logic signed [63:0] prod, prod_sh;
  logic signed [65:0] diff;
  logic mul_done, mul_sat;
  q_t mul_res;

  status_t raise_code;
  logic run_clear;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_wa] <= wd_d;
      umem[mem_wa] <= wd_u;
      rmem[mem_wa] <= wd_r;
    end
    if (x_we) begin
      xmem[bk_r] <= x_wd;
    end
    rd_d_r <= dmem[bk_r];
    rd_u_r <= umem[bk_r];
    rd_r_r <= rmem[bk_r];
    xrd_r  <= xmem[eidx_r];
  end

  // Restoring division of |num| * 2^FRAC_BITS by |den|, one quotient bit per cycle.
  assign trial = {1'b0, rem_r[Q_W-2:0], dvd_r[DW-1]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= DIV_END;
    end else if (div_start) begin
      dcnt_r  <= '0;
      dvd_r   <= {q_abs(div_num), {FRAC_BITS{1'b0}}};
      dvs_r   <= q_abs(div_den);
      rem_r   <= '0;
      quo_r   <= '0;
      neg_r   <= div_num[Q_W-1] ^ div_den[Q_W-1];
      dzero_r <= (div_den == '0);
    end else if (dcnt_r != DIV_END) begin
      dcnt_r <= dcnt_r + 1'b1;
      dvd_r  <= {dvd_r[DW-2:0], 1'b0};
      quo_r  <= {quo_r[DW-2:0], ~trial[Q_W]};
      rem_r  <= trial[Q_W] ? {rem_r[Q_W-2:0], dvd_r[DW-1]} : trial[Q_W-1:0];
    end
  end

  always_comb begin
    div_done = (dcnt_r == DIV_END);
    div_sat  = 1'b0;
    if (dzero_r) begin
      div_res = '0;
    end else if (!neg_r) begin
      div_sat = |quo_r[DW-1:Q_W-1];
      div_res = div_sat ? Q_MAX : q_t'(quo_r[Q_W-1:0]);
    end else begin
      div_sat = (|quo_r[DW-1:Q_W]) || (quo_r[Q_W-1] && (|quo_r[Q_W-2:0]));
      div_res = div_sat ? Q_MIN : q_t'(~quo_r[Q_W-1:0] + 1'b1);
    end
  end

  // Shift-add signed multiplication, one multiplier bit per cycle; the top bit subtracts.
  assign addend = !mplr_r[0]                ? '0 :
                  (mcnt_r == MUL_END - 1'b1) ? -(Q_W+2)'(mcand_r) : (Q_W+2)'(mcand_r);
  assign psum = hi_r + addend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= MUL_END;
    end else if (mul_start) begin
      mcnt_r  <= '0;
      mcand_r <= mul_a;
      mplr_r  <= mul_b;
      hi_r    <= '0;
      lo_r    <= '0;
    end else if (mcnt_r != MUL_END) begin
      mcnt_r <= mcnt_r + 1'b1;
      mplr_r <= {1'b0, mplr_r[Q_W-1:1]};
      hi_r   <= psum >>> 1;
      lo_r   <= {psum[0], lo_r[Q_W-1:1]};
    end
  end

  always_comb begin
    mul_done = (mcnt_r == MUL_END);
    prod     = {hi_r[Q_W-1:0], lo_r};
    prod_sh  = prod >>> FRAC_BITS;
    diff     = 66'(mul_min) - 66'(prod_sh);
    mul_sat  = (diff > SAT_HI) || (diff < SAT_LO);
    mul_res  = (diff > SAT_HI) ? Q_MAX : (diff < SAT_LO) ? Q_MIN : diff[Q_W-1:0];
  end

  always_comb begin
    unique case (state_r)
      S_MUL1:  mul_min = dia_r;
      S_MUL2:  mul_min = rhs_r;
      default: mul_min = rd_r_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    out_valid_nxt = out_valid_r;
    dia_nxt = dia_r;  sup_nxt = sup_r;  rhs_nxt = rhs_r;  last_nxt = last_r;
    prev_d_nxt = prev_d_r;  prev_u_nxt = prev_u_r;  prev_r_nxt = prev_r_r;
    p_nxt = p_r;  dnew_nxt = dnew_r;  x_nxt = x_r;
    bk_nxt = bk_r;  top_nxt = top_r;  eidx_nxt = eidx_r;
    o_idx_nxt = o_idx_r;  o_val_nxt = o_val_r;  o_st_nxt = o_st_r;  o_last_nxt = o_last_r;
    mem_we = 1'b0;  mem_wa = row_cnt_r[AW-1:0];
    wd_d = dnew_r;  wd_u = sup_r;  wd_r = mul_res;
    x_we = 1'b0;  x_wd = div_res;
    div_start = 1'b0;  div_num = prev_r_r;  div_den = prev_d_r;
    mul_start = 1'b0;  mul_a = p_r;  mul_b = prev_r_r;
    raise_code = ST_OK;
    run_clear  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dia_nxt  = in_diag_coeff;
          sup_nxt  = in_super_coeff;
          rhs_nxt  = in_rhs_value;
          last_nxt = in_row_last;
          priority if (row_cnt_r == MAX_CNT) begin
            // Rows beyond capacity are dropped; a last one still solves what is stored.
            raise_code = ST_OVERRUN;
            if (in_row_last) begin
              bk_nxt    = TOP_IDX;
              top_nxt   = TOP_IDX;
              div_start = 1'b1;
              state_nxt = S_BDIV;
            end
          end else if (row_cnt_r == '0) begin
            mem_we      = 1'b1;
            wd_d        = in_diag_coeff;
            wd_u        = in_super_coeff;
            wd_r        = in_rhs_value;
            prev_d_nxt  = in_diag_coeff;
            prev_u_nxt  = in_super_coeff;
            prev_r_nxt  = in_rhs_value;
            row_cnt_nxt = CW'(1);
            if (in_row_last) begin
              bk_nxt    = '0;
              top_nxt   = '0;
              div_start = 1'b1;
              div_num   = in_rhs_value;
              div_den   = in_diag_coeff;
              state_nxt = S_BDIV;
            end
          end else begin
            div_start = 1'b1;
            div_num   = in_sub_coeff;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          raise_code = dzero_r ? ST_ZERO_PIVOT : (div_sat ? ST_SAT : ST_OK);
          p_nxt      = div_res;
          mul_start  = 1'b1;
          mul_a      = div_res;
          mul_b      = prev_u_r;
          state_nxt  = S_MUL1;
        end
      end
      S_MUL1: begin
        if (mul_done) begin
          raise_code = mul_sat ? ST_SAT : ST_OK;
          dnew_nxt   = mul_res;
          mul_start  = 1'b1;
          state_nxt  = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mul_done) begin
          raise_code  = mul_sat ? ST_SAT : ST_OK;
          mem_we      = 1'b1;
          prev_d_nxt  = dnew_r;
          prev_u_nxt  = sup_r;
          prev_r_nxt  = mul_res;
          row_cnt_nxt = row_cnt_r + 1'b1;
          if (last_r) begin
            bk_nxt    = row_cnt_r[AW-1:0];
            top_nxt   = row_cnt_r[AW-1:0];
            div_start = 1'b1;
            div_num   = mul_res;
            div_den   = dnew_r;
            state_nxt = S_BDIV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_BDIV: begin
        if (div_done) begin
          raise_code = dzero_r ? ST_ZERO_PIVOT : (div_sat ? ST_SAT : ST_OK);
          x_we       = 1'b1;
          x_nxt      = div_res;
          if (bk_r == '0) begin
            eidx_nxt  = top_r;
            state_nxt = S_ERD;
          end else begin
            bk_nxt    = bk_r - 1'b1;
            state_nxt = S_BRD;
          end
        end
      end
      S_BRD: begin
        state_nxt = S_BLD;
      end
      S_BLD: begin
        mul_start = 1'b1;
        mul_a     = rd_u_r;
        mul_b     = x_r;
        state_nxt = S_BMUL;
      end
      S_BMUL: begin
        if (mul_done) begin
          raise_code = mul_sat ? ST_SAT : ST_OK;
          div_start  = 1'b1;
          div_num    = mul_res;
          div_den    = rd_d_r;
          state_nxt  = S_BDIV;
        end
      end
      S_ERD: begin
        state_nxt = S_ELD;
      end
      S_ELD: begin
        o_idx_nxt     = SOL_IDX_W'(eidx_r);
        o_val_nxt     = xrd_r;
        o_st_nxt      = status_r;
        o_last_nxt    = (eidx_r == '0);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EWT;
      end
      S_EWT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (eidx_r == '0) begin
            run_clear   = 1'b1;
            row_cnt_nxt = '0;
            state_nxt   = S_IDLE;
          end else begin
            eidx_nxt  = eidx_r - 1'b1;
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    status_nxt = status_r;
    if (status_rank(raise_code) > status_rank(status_r)) begin
      status_nxt = raise_code;
    end
    if (run_clear) begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_cnt_r   <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dia_r    <= dia_nxt;
    sup_r    <= sup_nxt;
    rhs_r    <= rhs_nxt;
    last_r   <= last_nxt;
    prev_d_r <= prev_d_nxt;
    prev_u_r <= prev_u_nxt;
    prev_r_r <= prev_r_nxt;
    p_r      <= p_nxt;
    dnew_r   <= dnew_nxt;
    x_r      <= x_nxt;
    bk_r     <= bk_nxt;
    top_r    <= top_nxt;
    eidx_r   <= eidx_nxt;
    o_idx_r  <= o_idx_nxt;
    o_val_r  <= o_val_nxt;
    o_st_r   <= o_st_nxt;
    o_last_r <= o_last_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_sol_index = o_idx_r;
  assign out_sol_value = o_val_r;
  assign out_status    = o_st_r;
  assign out_run_last  = o_last_r;

  a_valid_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_EWT))
    else $error("result shown outside the output wait state");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r <= MAX_CNT)
    else $error("row count beyond capacity");

  a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_run_last) |=> (row_cnt_r == '0 && status_r == ST_OK))
    else $error("row count or status not cleared after the final transfer");

  a_overrun_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && row_cnt_r == MAX_CNT) |=> (status_r == ST_OVERRUN))
    else $error("dropped row did not raise the overrun status");

endmodule
